FILE: rtl/stl_pkg.sv
// Package for the station table locator: payload structs, mode and register codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package stl_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RES_M = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RES_D = 2'd3;

	localparam logic [1:0] MODE_BOX = 2'd0;
	localparam logic [1:0] MODE_NEAR = 2'd1;
	localparam logic [1:0] MODE_ID = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               op;
		logic [7:0]         slot;
		logic signed [31:0] entry_id;
		logic signed [31:0] entry_proj_x;
		logic signed [31:0] entry_proj_y;
		logic signed [31:0] entry_lon;
		logic signed [31:0] entry_lat;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_id;
	} in_beat_t;

	typedef struct packed {
		logic       found;
		logic [7:0] station_index;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // write the held beat into the table
		logic first;     // beat accepted: clear best and hit tracking
		logic cmp;       // compare data read out this cycle
		logic rd;        // issue a table read
		logic finish;    // form the result
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;       // a first-match mode has matched
	} dp_sts_t;

endpackage

FILE: rtl/station_table_locate.sv
// Top level of the station table locator: config registers, beat capture,
// controller and datapath. Depends on stl_pkg, stl_ctrl, stl_datapath.
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+----------
// in       | in        | start & !busy        | in_beat
// out      | out       | done strobe          | out_beat
// cfg      | in        | cfg_we               | cfg_idx, cfg_data
//
// A query scans one table entry per cycle through the single memory read port;
// box and ID modes stop early on a match. Reset clears control state and the
// config registers; the table is undefined until loaded. Results cannot be
// stalled.
`timescale 1ns / 1ps
module station_table_locate
	import stl_pkg::*;
#(
	parameter int unsigned MAX_STATIONS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_beat_t              in_beat,
	output logic                  done,
	output out_beat_t             out_beat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

	logic [8:0]  count_q;
	logic [1:0]  mode_q;
	logic [30:0] res_m_q, res_d_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= '0;
			res_m_q <= '0;
			res_d_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_COUNT: count_q <= cfg_data[8:0];
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_RES_M: res_m_q <= cfg_data;
				REG_RES_D: res_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted beat for the whole operation.
	in_beat_t beat_q;
	logic     take;
	always_ff @(posedge clk) begin
		if (take) beat_q <= in_beat;
	end

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [AW-1:0] rd_addr, cmp_addr;

	stl_ctrl #(.MAX_STATIONS(MAX_STATIONS), .AW(AW)) u_ctrl (
		.clk, .arst_n, .start, .op(in_beat.op), .count(count_q),
		.sts, .busy, .take, .cmd, .rd_addr, .cmp_addr
	);

	stl_datapath #(.MAX_STATIONS(MAX_STATIONS), .AW(AW)) u_dp (
		.clk, .arst_n, .beat(beat_q), .rd_addr, .cmp_addr, .mode(mode_q),
		.res_m(res_m_q), .res_d(res_d_q), .cmd, .sts,
		.result(out_beat), .result_vld(done)
	);

endmodule

FILE: rtl/stl_datapath.sv
// Datapath: station memories, one-entry-per-cycle compare, best tracker, result.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_datapath
	import stl_pkg::*;
#(
	parameter int unsigned MAX_STATIONS = 256,
	parameter int unsigned AW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  in_beat_t        beat,
	input  logic [AW-1:0]   rd_addr,
	input  logic [AW-1:0]   cmp_addr,
	input  logic [1:0]      mode,
	input  logic [30:0]     res_m,
	input  logic [30:0]     res_d,
	input  dp_cmd_t         cmd,
	output dp_sts_t         sts,
	output out_beat_t       result,
	output logic            result_vld
);

	logic [31:0] mem_id  [MAX_STATIONS];
	logic [31:0] mem_px  [MAX_STATIONS];
	logic [31:0] mem_py  [MAX_STATIONS];
	logic [31:0] mem_lon [MAX_STATIONS];
	logic [31:0] mem_lat [MAX_STATIONS];
	logic [31:0] rd_id_q, rd_px_q, rd_py_q, rd_lon_q, rd_lat_q;

	// Table write on load, registered read during a scan.
	always_ff @(posedge clk) begin
		if (cmd.load && ({24'd0, beat.slot} < 32'(MAX_STATIONS))) begin
			mem_id[AW'(beat.slot)]  <= beat.entry_id;
			mem_px[AW'(beat.slot)]  <= beat.entry_proj_x;
			mem_py[AW'(beat.slot)]  <= beat.entry_proj_y;
			mem_lon[AW'(beat.slot)] <= beat.entry_lon;
			mem_lat[AW'(beat.slot)] <= beat.entry_lat;
		end
		if (cmd.rd) begin
			rd_id_q  <= mem_id[rd_addr];
			rd_px_q  <= mem_px[rd_addr];
			rd_py_q  <= mem_py[rd_addr];
			rd_lon_q <= mem_lon[rd_addr];
			rd_lat_q <= mem_lat[rd_addr];
		end
	end

	function automatic logic [32:0] adiff(input logic [31:0] a, input logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	logic [32:0] dpx, dpy, dlon, dlat;
	logic        box_hit, id_hit;
	assign dpx  = adiff(beat.query_x, rd_px_q);
	assign dpy  = adiff(beat.query_y, rd_py_q);
	assign dlon = adiff(beat.query_x, rd_lon_q);
	assign dlat = adiff(beat.query_y, rd_lat_q);
	assign box_hit = (({dpx, 1'b0} <= {3'd0, res_m}) && ({dpy, 1'b0} <= {3'd0, res_m})) ||
		(({dlon, 1'b0} <= {3'd0, res_d}) && ({dlat, 1'b0} <= {3'd0, res_d}));
	assign id_hit = (rd_id_q == beat.query_id);

	// Nearest mode is a two-stage chain: square, then sum and compare.
	logic          sq_vld_s1, sq_first_s1;
	logic [AW-1:0] sq_idx_s1;
	logic [65:0]   sqx_s1, sqy_s1;
	logic [66:0]   best_q;
	logic          best_vld_q;
	logic [AW-1:0] best_idx_q;
	logic [66:0]   dsum;
	assign dsum = {1'b0, sqx_s1} + {1'b0, sqy_s1};

	// The best distance only counts once an entry has been compared in this query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			sq_vld_s1 <= cmd.cmp && (mode == MODE_NEAR);
			if (cmd.first) begin
				best_vld_q <= 1'b0;
			end else if (sq_vld_s1) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_first_s1 <= cmd.cmp && (cmp_addr == '0);
		sq_idx_s1   <= cmp_addr;
		sqx_s1      <= dlon * dlon;
		sqy_s1      <= dlat * dlat;
		if (sq_vld_s1 && (sq_first_s1 || dsum <= best_q)) begin
			best_q     <= dsum;
			best_idx_q <= sq_idx_s1;
		end
	end

	// First-match tracking for box and ID modes.
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.first) begin
			hit_q <= 1'b0;
		end else if (cmd.cmp && !hit_q &&
			((mode == MODE_BOX && box_hit) || (mode == MODE_ID && id_hit))) begin
			hit_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.cmp && !hit_q) begin
			hit_idx_q <= cmp_addr;
		end
	end
	assign sts.hit = hit_q;

	// Result: nearest found only below (2*res_degrees)^2.
	logic [65:0] lim;
	logic        near_hit, fnd;
	assign lim = 66'({res_d, 1'b0}) * 66'({res_d, 1'b0});
	assign near_hit = best_vld_q && (best_q < {1'b0, lim});

	always_comb begin
		case (mode)
			MODE_BOX, MODE_ID: fnd = hit_q;
			MODE_NEAR:         fnd = near_hit;
			default:           fnd = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld <= 1'b0;
		end else begin
			result_vld <= cmd.finish;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.found <= fnd;
			result.station_index <= fnd ?
				8'(mode == MODE_NEAR ? best_idx_q : hit_idx_q) : 8'd0;
		end
	end

endmodule

FILE: rtl/stl_ctrl.sv
// Controller: sequences loads and the per-entry scan of a query.
// Depends on stl_pkg.
`timescale 1ns / 1ps
module stl_ctrl
	import stl_pkg::*;
#(
	parameter int unsigned MAX_STATIONS = 256,
	parameter int unsigned AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          op,
	input  logic [8:0]    count,
	input  dp_sts_t       sts,
	output logic          busy,
	output logic          take,
	output dp_cmd_t       cmd,
	output logic [AW-1:0] rd_addr,
	output logic [AW-1:0] cmp_addr
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t         state_q;
	logic [AW:0]    n_q;          // entries to search
	logic [AW:0]    rd_cnt_q;     // reads issued
	logic           cmp_vld_q;    // read data valid this cycle
	logic [AW-1:0]  cmp_q;
	logic [1:0]     drain_q;
	logic [AW:0]    n_clip;

	assign n_clip = (32'(count) > MAX_STATIONS) ?
		(AW+1)'(MAX_STATIONS) : (AW+1)'(count);
	assign take = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign rd_addr = rd_cnt_q[AW-1:0];
	assign cmp_addr = cmp_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == ST_LOAD);
		cmd.rd = (state_q == ST_SCAN) && (rd_cnt_q < n_q) && !sts.hit;
		cmd.cmp = cmp_vld_q;
		cmd.first = take;
		cmd.finish = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			rd_cnt_q  <= '0;
			cmp_vld_q <= 1'b0;
			cmp_q     <= '0;
			drain_q   <= '0;
		end else begin
			cmp_vld_q <= cmd.rd;
			if (cmd.rd) begin
				cmp_q    <= rd_cnt_q[AW-1:0];
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						rd_cnt_q <= '0;
						n_q      <= n_clip;
						state_q  <= (op == OP_LOAD) ? ST_LOAD : ST_SCAN;
					end
				end
				ST_LOAD: state_q <= ST_IDLE;
				ST_SCAN: begin
					if (!cmd.rd) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Let the compare and the squaring stage settle.
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
